// ===== sv/iht_pkg.sv =====
// Shared definitions for the ID handle table: sizes, operation and status codes,
// controller state type and the memory request bundle. No dependencies.
package iht_pkg;

  // Table depth and the number of usable IDs (IDs are eight bits wide).
  localparam int TABLE_DEPTH = 256;
  localparam int ID_LIMIT    = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
  localparam int ID_W        = 8;
  localparam int ID_AW       = $clog2(ID_LIMIT);
  localparam int CNT_W       = 9;
  localparam int VAL_W       = 64;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;

  localparam logic [CNT_W-1:0] ID_LIMIT_CNT = CNT_W'(ID_LIMIT);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd3;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } iht_state_t;

  // Read and write requests from the controller to both memories.
  typedef struct packed {
    logic             tbl_re;
    logic [ID_AW-1:0] tbl_raddr;
    logic             tbl_we;
    logic [ID_AW-1:0] tbl_waddr;
    logic [VAL_W-1:0] tbl_wdata;
    logic             stk_re;
    logic [ID_AW-1:0] stk_raddr;
    logic             stk_we;
    logic [ID_AW-1:0] stk_waddr;
    logic [ID_W-1:0]  stk_wdata;
  } iht_mem_req_t;

endpackage

// ===== sv/iht_if.sv =====
// Handshake channel interfaces for request and result words of the ID handle table.
// Depends on iht_pkg for field widths.
interface iht_in_if
  import iht_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [VAL_W-1:0] item_value;
  logic [ID_W-1:0]  item_id;

  modport source (output valid, output operation, output item_value, output item_id,
                  input ready);
  modport sink (input valid, input operation, input item_value, input item_id,
                output ready);
endinterface

interface iht_out_if
  import iht_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   assigned_id;
  logic [VAL_W-1:0]  read_value;

  modport source (output valid, output status, output assigned_id, output read_value,
                  input ready);
  modport sink (input valid, input status, input assigned_id, input read_value,
                output ready);
endinterface

// ===== sv/iht_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module iht_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next enabled read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/iht_ctrl.sv =====
// Controller of the ID handle table: request capture, free-stack and issue counters,
// read-modify-write decisions and the result register. Depends on iht_pkg and iht_if.
module iht_ctrl
  import iht_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  iht_in_if.sink           in_ch,
  iht_out_if.source        out_ch,
  output iht_mem_req_t     mem_req,
  input  logic [VAL_W-1:0] tbl_rdata,
  input  logic [ID_W-1:0]  stk_rdata
);

  iht_state_t state_r, state_nxt;

  logic [OP_W-1:0]   op_r;
  logic [VAL_W-1:0]  value_r;
  logic [ID_W-1:0]   id_r;
  logic [CNT_W-1:0]  free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]  issued_r, issued_nxt;

  logic              out_valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]   assigned_r, assigned_nxt;
  logic [VAL_W-1:0]  read_val_r, read_val_nxt;

  logic              accept;
  logic              exec_go;
  logic              id_bad;
  logic [CNT_W-1:0]  free_top;

  assign accept   = in_ch.valid && in_ch.ready;
  assign exec_go  = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);
  assign id_bad   = ({1'b0, id_r} >= issued_r);
  assign free_top = free_cnt_r - CNT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (exec_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake output of the request side.
  always_comb begin
    case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      default: in_ch.ready = 1'b0;
    endcase
  end

  // Decision logic: counters, result word and memory writes.
  always_comb begin
    free_cnt_nxt      = free_cnt_r;
    issued_nxt        = issued_r;
    status_nxt        = STAT_BAD;
    assigned_nxt      = '0;
    read_val_nxt      = '0;
    mem_req           = '0;
    mem_req.tbl_re    = accept;
    mem_req.tbl_raddr = in_ch.item_id[ID_AW-1:0];
    mem_req.stk_re    = accept;
    mem_req.stk_raddr = free_top[ID_AW-1:0];
    mem_req.tbl_wdata = value_r;
    mem_req.stk_wdata = id_r;
    mem_req.stk_waddr = free_cnt_r[ID_AW-1:0];
    case (op_r)
      OP_ADD: begin
        if (value_r == '0) begin
          status_nxt = STAT_ZERO;
        end else if (free_cnt_r != '0) begin
          status_nxt        = STAT_OK;
          assigned_nxt      = stk_rdata;
          free_cnt_nxt      = free_top;
          mem_req.tbl_we    = exec_go;
          mem_req.tbl_waddr = stk_rdata[ID_AW-1:0];
        end else if (issued_r < ID_LIMIT_CNT) begin
          status_nxt        = STAT_OK;
          assigned_nxt      = issued_r[ID_W-1:0];
          issued_nxt        = issued_r + CNT_W'(1);
          mem_req.tbl_we    = exec_go;
          mem_req.tbl_waddr = issued_r[ID_AW-1:0];
        end else begin
          status_nxt = STAT_FULL;
        end
      end
      OP_GET: begin
        if (!id_bad) begin
          status_nxt   = STAT_OK;
          read_val_nxt = tbl_rdata;
        end
      end
      OP_REMOVE: begin
        if (!id_bad && tbl_rdata != '0 && free_cnt_r < ID_LIMIT_CNT) begin
          status_nxt        = STAT_OK;
          free_cnt_nxt      = free_cnt_r + CNT_W'(1);
          mem_req.tbl_we    = exec_go;
          mem_req.tbl_waddr = id_r[ID_AW-1:0];
          mem_req.tbl_wdata = '0;
          mem_req.stk_we    = exec_go;
        end
      end
      default: status_nxt = STAT_BAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_cnt_r  <= '0;
      issued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        free_cnt_r  <= free_cnt_nxt;
        issued_r    <= issued_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Captured request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_ch.operation;
      value_r <= in_ch.item_value;
      id_r    <= in_ch.item_id;
    end
    if (exec_go) begin
      status_r   <= status_nxt;
      assigned_r <= assigned_nxt;
      read_val_r <= read_val_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.assigned_id = assigned_r;
  assign out_ch.read_value  = read_val_r;

endmodule

// ===== sv/id_handle_table_top.sv =====
// ID handle table: hands out eight-bit IDs for nonzero 64-bit values, reusing the most
// recently freed ID first, and answers get and remove requests by ID. Every request word
// yields exactly one result word. A request first reads the value table and the free stack,
// then decides and writes back; the next request is taken only once the block is back in
// idle, so no new request word is taken before the last one is through, and the decide step
// waits for an earlier result to be taken. A pending result waits in the output register
// without blocking a new request. Both memories start undefined; no clearing pass is needed
// after reset. Top level; depends on iht_pkg, iht_if, iht_ram and iht_ctrl.
module id_handle_table_top
  import iht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  iht_in_if.sink    in_ch,
  iht_out_if.source out_ch
);

  iht_mem_req_t     mem_req;
  logic [VAL_W-1:0] tbl_rdata;
  logic [ID_W-1:0]  stk_rdata;

  // Sequencing and decisions.
  iht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .mem_req   (mem_req),
    .tbl_rdata (tbl_rdata),
    .stk_rdata (stk_rdata)
  );

  // Stored values, one per ID.
  iht_ram #(
    .DATA_W (VAL_W),
    .ADDR_W (ID_AW)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (mem_req.tbl_we),
    .waddr (mem_req.tbl_waddr),
    .wdata (mem_req.tbl_wdata),
    .re    (mem_req.tbl_re),
    .raddr (mem_req.tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Free ID stack.
  iht_ram #(
    .DATA_W (ID_W),
    .ADDR_W (ID_AW)
  ) u_stk_ram (
    .clk   (clk),
    .we    (mem_req.stk_we),
    .waddr (mem_req.stk_waddr),
    .wdata (mem_req.stk_wdata),
    .re    (mem_req.stk_re),
    .raddr (mem_req.stk_raddr),
    .rdata (stk_rdata)
  );

endmodule
